FILE: rtl/pcc_pkg.sv
package pcc_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOP,
        S_MUL,
        S_SEL,
        S_DIV,
        S_CHK,
        S_DONE
    } t_state;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    localparam logic CMD_PERM = 1'b0;
    localparam logic CMD_COMB = 1'b1;

endpackage

FILE: rtl/permutation_combination_count.sv
// Channel   Handshake        Ports
// request   start, busy      i_cmd, i_total_count, i_chosen_count
// result    o_done strobe    o_count_value, o_overflow, o_range_error
//
// A word is taken when start is high and busy is low; busy stays high until
// the result strobe. Each step runs a shift-add multiply on the shared adder,
// plus a restoring divide for a combination; steps run until all are done or
// the result saturates. A range error goes straight to the result strobe.
// Reset returns the sequencer to idle. The result strobe is high for one cycle;
// the result is held until the next word is taken.
module permutation_combination_count #(
    parameter int COUNT_WIDTH  = 8,
    parameter int RESULT_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    input  logic                    i_cmd,
    input  logic [COUNT_WIDTH-1:0]  i_total_count,
    input  logic [COUNT_WIDTH-1:0]  i_chosen_count,
    output logic                    busy,
    output logic                    o_done,
    output logic [RESULT_WIDTH-1:0] o_count_value,
    output logic                    o_overflow,
    output logic                    o_range_error
);

    localparam int W     = RESULT_WIDTH + COUNT_WIDTH;
    localparam int CNT_W = $clog2(W + 1);

    pcc_pkg::t_state r_state, n_state;

    logic                    r_cmd, n_cmd;
    logic [COUNT_WIDTH-1:0]  r_n, n_n;
    logic [COUNT_WIDTH-1:0]  r_m, n_m;
    logic [COUNT_WIDTH-1:0]  r_steps, n_steps;
    logic [COUNT_WIDTH:0]    r_i, n_i;
    logic [RESULT_WIDTH-1:0] r_acc, n_acc;
    logic [W-1:0]            r_prod, n_prod;
    logic [COUNT_WIDTH-1:0]  r_mlt, n_mlt;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic [COUNT_WIDTH-1:0]  r_rem, n_rem;
    logic [W-1:0]            r_quo, n_quo;
    logic                    r_ovf, n_ovf;
    logic                    r_rerr, n_rerr;

    pcc_pkg::t_alu_op        alu_op;
    logic [W-1:0]            alu_a, alu_b, alu_sum;
    logic                    alu_carry;

    logic [COUNT_WIDTH-1:0]  n_minus_k;
    logic [COUNT_WIDTH-1:0]  kk;
    logic [COUNT_WIDTH:0]    rem_sh;
    logic [W-1:0]            chk_val;

    pcc_addsub #(
        .WIDTH (W)
    ) u_addsub (
        .i_op    (alu_op),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_sum   (alu_sum),
        .o_carry (alu_carry)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_n     <= n_n;
        r_m     <= n_m;
        r_steps <= n_steps;
        r_i     <= n_i;
        r_acc   <= n_acc;
        r_prod  <= n_prod;
        r_mlt   <= n_mlt;
        r_cnt   <= n_cnt;
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_ovf   <= n_ovf;
        r_rerr  <= n_rerr;
    end

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_n     = r_n;
        n_m     = r_m;
        n_steps = r_steps;
        n_i     = r_i;
        n_acc   = r_acc;
        n_prod  = r_prod;
        n_mlt   = r_mlt;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_ovf   = r_ovf;
        n_rerr  = r_rerr;
        alu_op  = pcc_pkg::ALU_ADD;
        alu_a   = '0;
        alu_b   = '0;

        n_minus_k = i_total_count - i_chosen_count;
        kk        = (i_chosen_count > n_minus_k) ? n_minus_k : i_chosen_count;
        rem_sh    = {r_rem, r_quo[W-1]};
        chk_val   = (r_cmd == pcc_pkg::CMD_PERM) ? r_prod : r_quo;

        unique case (r_state)
            pcc_pkg::S_IDLE: begin
                if (start) begin
                    n_cmd  = i_cmd;
                    n_n    = i_total_count;
                    n_i    = (COUNT_WIDTH+1)'(1);
                    n_ovf  = 1'b0;
                    n_rerr = (i_chosen_count > i_total_count);
                    n_acc  = (i_chosen_count > i_total_count) ? '0 : RESULT_WIDTH'(1);
                    if (i_cmd == pcc_pkg::CMD_COMB) begin
                        n_steps = kk;
                        n_m     = i_total_count - kk;
                    end else begin
                        n_steps = i_chosen_count;
                        n_m     = '0;
                    end
                    n_state = pcc_pkg::S_LOOP;
                end
            end
            pcc_pkg::S_LOOP: begin
                if (r_rerr || (r_i > {1'b0, r_steps})) begin
                    n_state = pcc_pkg::S_DONE;
                end else begin
                    if (r_cmd == pcc_pkg::CMD_PERM) begin
                        n_mlt = r_n - r_i[COUNT_WIDTH-1:0] + COUNT_WIDTH'(1);
                    end else begin
                        n_mlt = r_m + r_i[COUNT_WIDTH-1:0];
                    end
                    n_prod  = '0;
                    n_cnt   = CNT_W'(COUNT_WIDTH);
                    n_state = pcc_pkg::S_MUL;
                end
            end
            pcc_pkg::S_MUL: begin
                alu_op = pcc_pkg::ALU_ADD;
                alu_a  = {r_prod[W-2:0], 1'b0};
                alu_b  = r_mlt[COUNT_WIDTH-1] ? W'(r_acc) : '0;
                n_prod = alu_sum;
                n_mlt  = {r_mlt[COUNT_WIDTH-2:0], 1'b0};
                n_cnt  = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_state = pcc_pkg::S_SEL;
                end
            end
            pcc_pkg::S_SEL: begin
                if (r_cmd == pcc_pkg::CMD_PERM) begin
                    n_state = pcc_pkg::S_CHK;
                end else begin
                    n_quo   = r_prod;
                    n_rem   = '0;
                    n_cnt   = CNT_W'(W);
                    n_state = pcc_pkg::S_DIV;
                end
            end
            pcc_pkg::S_DIV: begin
                alu_op = pcc_pkg::ALU_SUB;
                alu_a  = W'(rem_sh);
                alu_b  = W'(r_i);
                n_rem  = alu_carry ? alu_sum[COUNT_WIDTH-1:0] : rem_sh[COUNT_WIDTH-1:0];
                n_quo  = {r_quo[W-2:0], alu_carry};
                n_cnt  = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_state = pcc_pkg::S_CHK;
                end
            end
            pcc_pkg::S_CHK: begin
                if (|chk_val[W-1:RESULT_WIDTH]) begin
                    n_ovf   = 1'b1;
                    n_acc   = '1;
                    n_state = pcc_pkg::S_DONE;
                end else begin
                    n_acc   = chk_val[RESULT_WIDTH-1:0];
                    n_i     = r_i + (COUNT_WIDTH+1)'(1);
                    n_state = pcc_pkg::S_LOOP;
                end
            end
            pcc_pkg::S_DONE: begin
                n_state = pcc_pkg::S_IDLE;
            end
            default: begin
                n_state = pcc_pkg::S_IDLE;
            end
        endcase
    end

    assign busy          = (r_state != pcc_pkg::S_IDLE);
    assign o_done        = (r_state == pcc_pkg::S_DONE);
    assign o_count_value = r_acc;
    assign o_overflow    = r_ovf;
    assign o_range_error = r_rerr;

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result strobe outside a busy period");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_done))
        else $error("accepted word did not start the sequencer");

    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_range_error) |-> (o_count_value == '0 && !o_overflow))
        else $error("range error with nonzero count or overflow");

    a_ovf_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_overflow) |-> (&o_count_value))
        else $error("overflow without saturated count");

endmodule

FILE: rtl/pcc_addsub.sv
module pcc_addsub #(
    parameter int WIDTH = 40
) (
    input  pcc_pkg::t_alu_op   i_op,
    input  logic [WIDTH-1:0]   i_a,
    input  logic [WIDTH-1:0]   i_b,
    output logic [WIDTH-1:0]   o_sum,
    output logic               o_carry
);

    logic [WIDTH-1:0] b_op;
    logic             sub;
    logic [WIDTH:0]   full;

    always_comb begin
        sub   = (i_op == pcc_pkg::ALU_SUB);
        b_op  = sub ? ~i_b : i_b;
        full  = {1'b0, i_a} + {1'b0, b_op} + {{WIDTH{1'b0}}, sub};
        o_sum   = full[WIDTH-1:0];
        o_carry = full[WIDTH];
    end

endmodule
